// ===== hdl/transposition_table_probe_store_macros.svh =====
// ----------------------------------------------------------------------------
// Transposition table probe store assertion macros
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Expression must hold at every rising clock edge outside reset.
`define TTPS_ASSERT(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// When the antecedent holds, the consequent must hold in the next cycle.
`define TTPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TTPS_ASSERT(label, clk, rst_n, expr, msg)
`define TTPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/ttps_pkg.sv =====
// ----------------------------------------------------------------------------
// Transposition table probe store package
// Shared types, register codes and constants of the probe store.
// ----------------------------------------------------------------------------
`default_nettype none

package ttps_pkg;

	localparam int KEY_W         = 64;
	localparam int ENTRIES_DEF   = 65536;
	localparam int MAX_DEPTH_DEF = 64;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;

	localparam logic [14:0] THR_RST     = 15'd28000;
	localparam logic [14:0] MATE_RST    = 15'd29000;
	localparam logic [31:0] NO_MOVE_RST = 32'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MATE_THRESHOLD = 2'd0,
		CFG_MATE_SCORE     = 2'd1,
		CFG_NO_MOVE_CODE   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_STORE = 1'b0,
		OP_PROBE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		BOUND_UPPER   = 2'd0,
		BOUND_LOWER   = 2'd1,
		BOUND_EXACT   = 2'd2,
		BOUND_INVALID = 2'd3
	} bound_t;

	typedef struct packed {
		logic               op;
		logic [KEY_W-1:0]   key;
		logic [31:0]        move_in;
		logic signed [15:0] score_in;
		logic [1:0]         bound_flag;
		logic [5:0]         depth_in;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic [5:0]         ply;
	} in_item_t;

	typedef struct packed {
		logic               key_match;
		logic [31:0]        move_out;
		logic               depth_ok;
		logic               cutoff;
		logic signed [15:0] score_out;
	} out_item_t;

	// One table entry as kept in the memory.
	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [31:0]        move;
		logic signed [15:0] score;
		logic [5:0]         depth;
		bound_t             flag;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_ACCESS,
		ST_EVAL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_item;
		logic idx_step;
		logic clr_write;
		logic mem_write;
		logic mem_read;
		logic eval_load;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic op_probe;
		logic out_free;
	} ctrl_sts_t;

	function automatic bit is_pow2(input int n);
		return (n & (n - 1)) == 0;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/transposition_table_probe_store.sv =====
// ----------------------------------------------------------------------------
// Transposition table probe store
// Direct-mapped, always-replace search cache with probe-time bound rules.
// ----------------------------------------------------------------------------
// After reset the block first runs a clearing pass that writes every one of
// the ENTRIES table entries to empty, one entry per cycle, with in_ready held
// low throughout; configuration writes are taken throughout as well. Items are
// then handled one at a time, paced by the single memory port and the
// controller sequence: a store goes through accept, write and result load,
// and a probe through accept, read, evaluate and result load. When ENTRIES is
// not a power of two the entry index is the key modulo ENTRIES, built up one
// key nibble per cycle from a small constant residue table, which adds an
// index phase to every item. The result sits in an output register, so the
// next item may be accepted while a finished result still waits for
// out_ready; that item finishes once the register frees up. Every store
// answers with a result whose fields are all zero. A probe reports a key match
// and the stored move (or no_move_code on a miss); when the stored depth is at
// least depth_in it also gives the ply-adjusted score and the bound-rule
// cutoff. Configuration is to be written only while the block is idle; the
// block itself does not enforce this.
`default_nettype none

`include "transposition_table_probe_store_macros.svh"

module transposition_table_probe_store import ttps_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Item input
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	// Result output
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	// Configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// Register writes always complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	ttps_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	ttps_datapath #(
		.ENTRIES  (ENTRIES),
		.MAX_DEPTH(MAX_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The result register is only loaded when it is empty or being drained.
	`TTPS_ASSERT(a_out_load_free, clk, arst_n,
		!cmd.out_load || !out_valid || out_ready, "result overwritten before transfer")

	// Only one item is in flight: a transfer drops in_ready for the next cycle.
	`TTPS_ASSERT_NEXT(a_one_in_flight, clk, arst_n,
		in_valid && in_ready, !in_ready, "second item accepted while busy")

	// A cutoff needs a depth hit, and a depth hit needs a key match.
	`TTPS_ASSERT(a_result_order, clk, arst_n,
		!out_valid || ((!out_data.cutoff || out_data.depth_ok)
		&& (!out_data.depth_ok || out_data.key_match)), "inconsistent result flags")

endmodule

`default_nettype wire

// ===== hdl/ttps_mem.sv =====
// ----------------------------------------------------------------------------
// Transposition table entry memory
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_mem #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 121
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ttps_datapath.sv =====
// ----------------------------------------------------------------------------
// Transposition table datapath
// Item and configuration registers, index unit, entry memory, probe
// evaluation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_datapath import ttps_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire in_item_t              in_data,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output out_item_t                  out_data,
	input  wire ctrl_cmd_t             cmd,
	output ctrl_sts_t                  sts
);

	localparam int IW = $clog2(ENTRIES);
	localparam bit IDX_POW2 = is_pow2(ENTRIES);
	localparam logic [IW:0] ENTRIES_C = (IW + 1)'(ENTRIES);
	localparam logic [IW-1:0] LAST_ADDR = IW'(ENTRIES - 1);
	localparam logic [7:0] DEPTH_CAP = 8'(MAX_DEPTH - 1);
	localparam int EW = $bits(entry_t);
	localparam int NIB_N = KEY_W / 4;
	localparam int NW = $clog2(NIB_N);

	in_item_t item_q;
	logic [14:0] thr_q;
	logic [14:0] mate_q;
	logic [31:0] nomove_q;

	logic [KEY_W-1:0] key_sh_q;
	logic [NW-1:0] nib_q;
	logic [IW-1:0] res_tab [NIB_N * 16];
	logic [IW-1:0] rem_q;
	logic [IW:0] rem_t;
	logic [IW-1:0] rem_nxt;
	logic [IW-1:0] idx;
	logic [IW-1:0] clr_addr_q;
	logic [IW-1:0] mem_addr;

	logic signed [16:0] thr_s;
	logic signed [16:0] neg_thr;
	logic signed [16:0] sc_in_s;
	logic [15:0] mate16;
	logic [15:0] st_score;
	logic [5:0] depth_sat;
	entry_t wr_entry;
	entry_t rd;
	logic [EW-1:0] mem_wdata;
	logic [EW-1:0] mem_rdata;

	logic signed [16:0] rd_sc;
	logic signed [16:0] ply_s;
	logic signed [16:0] adj;
	logic hit;
	logic dok;

	logic hit_q;
	logic dok_q;
	logic signed [16:0] adj_q;
	bound_t flag_q;
	logic [31:0] mv_q;

	logic signed [16:0] alpha_s;
	logic signed [16:0] beta_s;
	logic signed [16:0] fin_sc;
	logic cut;
	out_item_t res;
	logic out_valid_q;
	out_item_t out_q;

	// Residue of one key nibble at its position: (val * 2^(4 * pos)) mod ENTRIES.
	function automatic logic [IW-1:0] nib_res(input int pos, input int val);
		longint p;
		int i;
		p = 1;
		for (i = 0; i < 4 * pos; i++) begin
			p = (p * 2) % ENTRIES;
		end
		return IW'((p * val) % ENTRIES);
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RST;
			mate_q   <= MATE_RST;
			nomove_q <= NO_MOVE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MATE_THRESHOLD: thr_q    <= cfg_data[14:0];
				CFG_MATE_SCORE:     mate_q   <= cfg_data[14:0];
				CFG_NO_MOVE_CODE:   nomove_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
	end

	// Constant residue table, one row of 16 values per key nibble position.
	for (genvar g = 0; g < NIB_N * 16; g++) begin : g_res_tab
		localparam logic [IW-1:0] RES_G = nib_res(g >> 4, g & 15);
		assign res_tab[g] = RES_G;
	end

	// Key modulo ENTRIES: the residues of the key nibbles are summed one per
	// step, least significant first, and folded back below ENTRIES each time.
	assign rem_t = {1'b0, rem_q} + {1'b0, res_tab[{nib_q, key_sh_q[3:0]}]};
	assign rem_nxt = (rem_t >= ENTRIES_C) ? IW'(rem_t - ENTRIES_C) : rem_t[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_sh_q <= in_data.key;
			nib_q    <= '0;
			rem_q    <= '0;
		end else if (cmd.idx_step) begin
			key_sh_q <= {4'd0, key_sh_q[KEY_W-1:4]};
			nib_q    <= nib_q + NW'(1);
			rem_q    <= rem_nxt;
		end
	end

	assign idx = IDX_POW2 ? item_q.key[IW-1:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_write) begin
			clr_addr_q <= clr_addr_q + IW'(1);
		end
	end

	// Store path: mate clamp and depth saturation.
	assign thr_s   = {2'b00, thr_q};
	assign neg_thr = -thr_s;
	assign sc_in_s = {item_q.score_in[15], item_q.score_in};
	assign mate16  = {1'b0, mate_q};

	always_comb begin
		if (sc_in_s >= thr_s) begin
			st_score = mate16;
		end else if (sc_in_s <= neg_thr) begin
			st_score = 16'd0 - mate16;
		end else begin
			st_score = item_q.score_in;
		end
	end

	assign depth_sat = ({2'b00, item_q.depth_in} > DEPTH_CAP) ? DEPTH_CAP[5:0]
		: item_q.depth_in;

	always_comb begin
		wr_entry.valid = 1'b1;
		wr_entry.key   = item_q.key;
		wr_entry.move  = item_q.move_in;
		wr_entry.score = st_score;
		wr_entry.depth = depth_sat;
		wr_entry.flag  = bound_t'(item_q.bound_flag);
	end

	// A cleared entry is all zero, so its valid bit is low.
	assign mem_wdata = cmd.clr_write ? '0 : wr_entry;
	assign mem_addr  = cmd.clr_write ? clr_addr_q : idx;

	ttps_mem #(
		.DEPTH(ENTRIES),
		.WIDTH(EW)
	) u_mem (
		.clk  (clk),
		.we   (cmd.clr_write | cmd.mem_write),
		.re   (cmd.mem_read),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Probe evaluation: tag and depth check, mate score adjustment by ply.
	assign rd    = entry_t'(mem_rdata);
	assign hit   = rd.valid && (rd.key == item_q.key);
	assign dok   = hit && (rd.depth >= item_q.depth_in);
	assign rd_sc = {rd.score[15], rd.score};
	assign ply_s = {11'd0, item_q.ply};

	always_comb begin
		if (rd_sc >= thr_s) begin
			adj = rd_sc - ply_s;
		end else if (rd_sc <= neg_thr) begin
			adj = rd_sc + ply_s;
		end else begin
			adj = rd_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_load) begin
			hit_q  <= hit;
			dok_q  <= dok;
			adj_q  <= adj;
			flag_q <= rd.flag;
			mv_q   <= rd.move;
		end
	end

	// Bound rules against the window.
	assign alpha_s = {item_q.alpha[15], item_q.alpha};
	assign beta_s  = {item_q.beta[15], item_q.beta};

	always_comb begin
		fin_sc = adj_q;
		cut    = 1'b0;
		case (flag_q)
			BOUND_UPPER: begin
				if (adj_q <= alpha_s) begin
					fin_sc = alpha_s;
					cut    = 1'b1;
				end
			end
			BOUND_LOWER: begin
				if (adj_q >= beta_s) begin
					fin_sc = beta_s;
					cut    = 1'b1;
				end
			end
			BOUND_EXACT: cut = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		if (item_q.op == OP_PROBE) begin
			res.key_match = hit_q;
			res.move_out  = hit_q ? mv_q : nomove_q;
			res.depth_ok  = dok_q;
			res.cutoff    = dok_q & cut;
			res.score_out = dok_q ? fin_sc[15:0] : 16'sd0;
		end else begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.clr_last = (clr_addr_q == LAST_ADDR);
	assign sts.op_probe = (item_q.op == OP_PROBE);
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// ===== hdl/ttps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Transposition table controller
// Sequences the clearing pass and each store or probe through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_ctrl import ttps_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output ctrl_cmd_t      cmd,
	input  wire ctrl_sts_t sts
);

	localparam bit IDX_POW2 = is_pow2(ENTRIES);
	localparam int CW = $clog2(KEY_W / 4);
	localparam logic [CW-1:0] CNT_LAST = CW'(KEY_W / 4 - 1);

	state_t state_q;
	state_t state_nxt;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Nibble counter of the index unit; wraps back to zero on the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_INDEX) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = IDX_POW2 ? ST_ACCESS : ST_INDEX;
				end
			end
			ST_INDEX: begin
				if (cnt_q == CNT_LAST) begin
					state_nxt = ST_ACCESS;
				end
			end
			ST_ACCESS: state_nxt = sts.op_probe ? ST_EVAL : ST_FINISH;
			ST_EVAL:   state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_write = 1'b1;
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_INDEX: cmd.idx_step = 1'b1;
			ST_ACCESS: begin
				cmd.mem_write = !sts.op_probe;
				cmd.mem_read  = sts.op_probe;
			end
			ST_EVAL:   cmd.eval_load = 1'b1;
			ST_FINISH: cmd.out_load  = sts.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/transposition_table_probe_store_tb.sv =====
// ----------------------------------------------------------------------------
// Transposition table probe store testbench
// Drives stores and probes into the probe store through its valid/ready
// channels with random idling on both sides, keeps a shadow copy of the table
// and its registers, and checks every result field against the shadow's
// prediction over several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module transposition_table_probe_store_tb;
	import ttps_pkg::*;

	// Generous bound: the clearing pass after reset, then every item at its
	// slowest with the longest sender gap and receiver stall, several times over.
	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int LONG_HOLD = 400;
	localparam int POOL_N = 24;

	// Shadow of the table: tracks every entry written so far and the three
	// registers, predicts the result of each accepted item and checks the
	// results in order of acceptance.
	class tt_shadow;
		entry_t slots[int];
		out_item_t want_results[$];
		int mate_thr;
		int mate_val;
		logic [31:0] no_move;
		int mismatches;
		int results_seen;

		function new();
			mate_thr = int'(THR_RST);
			mate_val = int'(MATE_RST);
			no_move = NO_MOVE_RST;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void write_reg(cfg_reg_t r, logic [31:0] v);
			case (r)
				CFG_MATE_THRESHOLD: mate_thr = int'(v[14:0]);
				CFG_MATE_SCORE: mate_val = int'(v[14:0]);
				CFG_NO_MOVE_CODE: no_move = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return want_results.size();
		endfunction

		// Works out the result of one accepted item and updates the table.
		function void note_item(in_item_t it);
			out_item_t want;
			entry_t e;
			int idx;
			int s;
			int a;
			int b;
			want = '0;
			idx = int'(it.key % ENTRIES_DEF);
			if (op_t'(it.op) == OP_STORE) begin
				// Scores at or past the threshold are pinned to the mate magnitude.
				s = $signed(it.score_in);
				if (s >= mate_thr) begin
					s = mate_val;
				end else if (s <= -mate_thr) begin
					s = -mate_val;
				end
				e.valid = 1'b1;
				e.key = it.key;
				e.move = it.move_in;
				e.score = 16'(s);
				e.depth = it.depth_in;
				e.flag = bound_t'(it.bound_flag);
				slots[idx] = e;
			end else begin
				want.move_out = no_move;
				if (slots.exists(idx) && slots[idx].key == it.key) begin
					e = slots[idx];
					want.key_match = 1'b1;
					want.move_out = e.move;
					if (e.depth >= it.depth_in) begin
						want.depth_ok = 1'b1;
						s = $signed(e.score);
						// Mate distances are measured from the probing node.
						if (s >= mate_thr) begin
							s = s - int'(it.ply);
						end else if (s <= -mate_thr) begin
							s = s + int'(it.ply);
						end
						a = $signed(it.alpha);
						b = $signed(it.beta);
						case (e.flag)
							BOUND_UPPER: begin
								if (s <= a) begin
									s = a;
									want.cutoff = 1'b1;
								end
							end
							BOUND_LOWER: begin
								if (s >= b) begin
									s = b;
									want.cutoff = 1'b1;
								end
							end
							BOUND_EXACT: want.cutoff = 1'b1;
							default: ;
						endcase
						want.score_out = 16'(s);
					end
				end
			end
			want_results.push_back(want);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("[%0t] result %0d: %s got %h expected %h",
				$time, results_seen, what, got, want);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			results_seen++;
			if (want_results.size() == 0) begin
				report_mismatch("result with nothing pending, move_out", got.move_out, '0);
				return;
			end
			want = want_results.pop_front();
			if (got.key_match !== want.key_match)
				report_mismatch("key_match", got.key_match, want.key_match);
			if (got.move_out !== want.move_out)
				report_mismatch("move_out", got.move_out, want.move_out);
			if (got.depth_ok !== want.depth_ok)
				report_mismatch("depth_ok", got.depth_ok, want.depth_ok);
			if (got.cutoff !== want.cutoff)
				report_mismatch("cutoff", got.cutoff, want.cutoff);
			if (got.score_out !== want.score_out)
				report_mismatch("score_out", got.score_out, want.score_out);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tt_shadow shadow;

	// Idling controls for the sender and the receiver, set by the stimulus.
	bit tx_steady;
	bit rx_steady;
	bit long_hold_req;

	// Keys are drawn from a small pool spread over a few table slots, so that
	// stores replace each other and probes mostly find something.
	logic [63:0] key_pool[POOL_N];
	logic [15:0] slot_idx[6] = '{16'h0000, 16'hFFFF, 16'h0005, 16'h8000, 16'h1234, 16'h7FFF};

	transposition_table_probe_store u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Every result transfer is checked against the oldest prediction. Values
	// are read at the edge, before any of this edge's updates land.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			shadow.check_result(out_data);
		end
	end

	// Receiver: mostly ready, with short stalls, a few long ones, and on
	// request one very long hold-off that lets the block back up into its
	// input. The hold-off is counted here, cycle by cycle.
	initial begin : receiver
		int rx_hold;
		int r;
		rx_hold = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rx_hold = LONG_HOLD;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				r = $urandom_range(99);
				if (!rx_steady) begin
					if (r < 18) begin
						rx_hold = $urandom_range(3, 1);
					end else if (r < 21) begin
						rx_hold = $urandom_range(40, 8);
					end
				end
			end
		end
	end

	// Run limit. Reaching it means the block hung or lost results.
	initial begin : watchdog
		int unsigned n;
		for (n = 0; n < CYCLE_LIMIT; n++) begin
			@(posedge clk);
		end
		$display("transposition_table_probe_store_tb: FAIL");
		$finish;
	end

	function automatic logic [63:0] fresh_key();
		return {48'({$urandom, $urandom}), slot_idx[$urandom_range(5)]};
	endfunction

	// Score or window value: mostly small, often right around the mate
	// threshold on either side, sometimes an extreme or anything at all.
	function automatic logic signed [15:0] rand_score();
		int v;
		int r;
		r = $urandom_range(99);
		if (r < 45) begin
			v = int'($urandom_range(800)) - 400;
		end else if (r < 70) begin
			v = shadow.mate_thr + int'($urandom_range(6)) - 3;
			if ($urandom_range(1)) v = -v;
		end else if (r < 78) begin
			case ($urandom_range(3))
				0: v = -32768;
				1: v = -32767;
				2: v = 32767;
				default: v = 0;
			endcase
		end else begin
			v = $signed(16'($urandom));
		end
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	function automatic in_item_t make_store(logic [63:0] key, logic [31:0] move, int score,
		bound_t flag, int depth);
		in_item_t it;
		it = '0;
		it.op = OP_STORE;
		it.key = key;
		it.move_in = move;
		it.score_in = 16'(score);
		it.bound_flag = flag;
		it.depth_in = 6'(depth);
		return it;
	endfunction

	function automatic in_item_t make_probe(logic [63:0] key, int depth, int alpha, int beta,
		int ply);
		in_item_t it;
		it = '0;
		it.op = OP_PROBE;
		it.key = key;
		it.depth_in = 6'(depth);
		it.alpha = 16'(alpha);
		it.beta = 16'(beta);
		it.ply = 6'(ply);
		return it;
	endfunction

	// Offers one item, holds it until the transfer, then maybe idles. Valid is
	// only lowered when a gap follows, so back-to-back items keep it high.
	task automatic send_item(input in_item_t it);
		int r;
		int gap;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		shadow.note_item(it);
		gap = 0;
		if (!tx_steady) begin
			r = $urandom_range(99);
			if (r < 38) begin
				gap = $urandom_range(3, 1);
			end else if (r < 45) begin
				gap = $urandom_range(40, 8);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender stops and waits until every predicted result has been checked.
	task automatic drain();
		in_valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
	endtask

	// Writes all three registers in one burst; valid stays high between them.
	task automatic set_regs(input logic [31:0] thr, input logic [31:0] mate,
		input logic [31:0] nomove);
		logic [31:0] vals[3];
		int i;
		vals[0] = thr;
		vals[1] = mate;
		vals[2] = nomove;
		cfg_valid <= 1'b1;
		for (i = 0; i < 3; i++) begin
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			shadow.write_reg(cfg_reg_t'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random traffic: stores and probes over the key pool, with some probes on
	// the right slot but the wrong tag and some on untouched slots.
	task automatic run_random(input int n, input int hold_at);
		in_item_t it;
		int i;
		int r;
		int k;
		for (i = 0; i < n; i++) begin
			if (i == hold_at) long_hold_req = 1'b1;
			it.op = ($urandom_range(99) < 40) ? OP_STORE : OP_PROBE;
			it.key = key_pool[$urandom_range(POOL_N - 1)];
			if (op_t'(it.op) == OP_PROBE) begin
				r = $urandom_range(99);
				if (r < 15) begin
					it.key[63:16] = 48'({$urandom, $urandom});
				end else if (r < 25) begin
					it.key = {$urandom, $urandom};
				end
			end else if ($urandom_range(99) < 5) begin
				k = $urandom_range(POOL_N - 1);
				key_pool[k] = fresh_key();
				it.key = key_pool[k];
			end
			it.move_in = $urandom;
			it.score_in = rand_score();
			it.bound_flag = 2'($urandom_range(3));
			if (op_t'(it.op) == OP_PROBE && $urandom_range(99) < 60) begin
				it.depth_in = 6'($urandom_range(20));
			end else begin
				it.depth_in = 6'($urandom_range(63));
			end
			it.alpha = rand_score();
			it.beta = rand_score();
			it.ply = 6'($urandom_range(63));
			send_item(it);
		end
	endtask

	initial begin : stimulus
		logic [63:0] k1;
		logic [63:0] ones;
		int i;
		shadow = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MATE_THRESHOLD;
		cfg_data = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		long_hold_req = 1'b0;
		for (i = 0; i < POOL_N; i++) key_pool[i] = fresh_key();
		k1 = 64'h0123_4567_89AB_0005;
		ones = '1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, reset register values. The first transfer waits out
		// the clearing pass.
		// An empty slot must miss even for the all-zero and all-one keys.
		send_item(make_probe('0, 0, -32767, 32767, 0));
		send_item(make_probe(ones, 0, -32767, 32767, 0));
		// Extremes: top score is pinned to the mate score, then shortened by ply.
		send_item(make_store(ones, 32'hFFFF_FFFF, 32767, BOUND_EXACT, 63));
		send_item(make_probe(ones, 63, -32767, 32767, 63));
		// The most negative score is stored as minus the mate score; a window
		// edge of -32768 comes back unchanged on a lower-bound cutoff.
		send_item(make_store('0, '0, -32768, BOUND_LOWER, 0));
		send_item(make_probe('0, 0, 32767, -32768, 0));
		// Upper bound: too shallow, cutoff exactly at alpha, no cutoff just above.
		send_item(make_store(k1, 32'h0000_1234, 100, BOUND_UPPER, 10));
		send_item(make_probe(k1, 11, 100, 200, 0));
		send_item(make_probe(k1, 10, 100, 200, 0));
		send_item(make_probe(k1, 0, 99, 200, 0));
		// Same slot, different tag: a miss.
		send_item(make_probe(k1 ^ 64'h8000_0000_0000_0000, 0, 0, 0, 0));
		// Lower bound: cutoff exactly at beta, none just above.
		send_item(make_store(k1, 32'h8765_4321, 100, BOUND_LOWER, 10));
		send_item(make_probe(k1, 3, -100, 100, 7));
		send_item(make_probe(k1, 3, -100, 101, 7));
		// Negative mate at exactly the threshold, moved toward zero by ply.
		send_item(make_store(k1, 32'h0000_0001, -28000, BOUND_EXACT, 20));
		send_item(make_probe(k1, 20, -32767, 32767, 5));
		// Just below the threshold, invalid bound: kept as is, never a cutoff.
		send_item(make_store(k1, 32'hFFFF_0000, 27999, BOUND_INVALID, 63));
		send_item(make_probe(k1, 63, 32767, -32767, 63));
		// Positive mate with an upper bound against both window extremes.
		send_item(make_store(k1, 32'h0F0F_F0F0, 28000, BOUND_UPPER, 1));
		send_item(make_probe(k1, 1, -32768, 0, 1));
		send_item(make_probe(k1, 1, 32767, 0, 1));

		// Random part at reset settings, with one long receiver hold-off that
		// backs the block up into its input.
		run_random(150, 60);
		drain();

		// Zero threshold: every score counts as mate, non-negative ones as positive mate.
		set_regs(32'h0000_0000, 32'h0000_7FFF, 32'hFFFF_FFFF);
		run_random(120, -1);
		drain();

		// Top threshold, zero mate score; the unused upper bits are all set.
		set_regs(32'hFFFF_FFFF, 32'hFFFF_8000, 32'hA5C3_0F96);
		run_random(120, -1);
		drain();

		// Random settings with both sides running flat out.
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		set_regs({17'($urandom), 15'($urandom_range(32767))},
			{17'($urandom), 15'($urandom_range(32767))}, $urandom);
		run_random(130, -1);
		drain();
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		// Back to the usual mate settings with a fresh miss code.
		set_regs(32'd28000, 32'd29000, $urandom);
		run_random(130, -1);
		drain();

		// Let any stray result show up before deciding.
		repeat (20) @(posedge clk);
		if (shadow.mismatches == 0) begin
			$display("transposition_table_probe_store_tb: PASS");
		end else begin
			$display("transposition_table_probe_store_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== transposition_table_probe_store.f =====
+incdir+hdl
hdl/ttps_pkg.sv
hdl/ttps_mem.sv
hdl/ttps_datapath.sv
hdl/ttps_ctrl.sv
hdl/transposition_table_probe_store.sv
tb/transposition_table_probe_store_tb.sv
